>>> src/qdc_pkg.sv
// Package for the QDC block word decoder: widths, word codes, result kinds and stage types.
package qdc_pkg;

  // Block constants
  localparam int CHANNELS           = 32;
  localparam int OVERFLOW_LEVEL     = 4096;
  localparam int HEADER_WORDS       = 4;
  localparam int GAIN_FRACTION_BITS = 16;
  localparam int OVERFLOW_MARGIN    = 10;

  // Field widths
  localparam int WORD_W   = 32;
  localparam int KIND_W   = 4;
  localparam int CH_W     = 5;
  localparam int ADC_W    = 12;
  localparam int GAIN_W   = 32;
  localparam int OFS_W    = 24;
  localparam int ENERGY_W = 32;
  localparam int EVT_W    = 24;
  localparam int STORE_W  = 6;
  localparam int POS_W    = 3;

  // Derived widths
  localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PROD_W   = ADC_W + 1 + GAIN_W;   // unsigned value times signed gain
  localparam int SUM_W    = PROD_W + 1;
  localparam int CNT_LIM_W = ADC_W + 1;

  // Word layout
  localparam logic [4:0] SEP_CODE     = 5'h13;
  localparam logic [2:0] TYPE_HEADER  = 3'd2;
  localparam logic [2:0] TYPE_DATUM   = 3'd0;
  localparam logic [2:0] TYPE_EOE     = 3'd4;
  localparam logic [2:0] TYPE_INVALID = 3'd6;

  // Result kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_CAL     = 4'd0,
    KIND_PKT_HDR = 4'd1,
    KIND_ADC_HDR = 4'd2,
    KIND_DATUM   = 4'd3,
    KIND_EOE     = 4'd4,
    KIND_INVALID = 4'd5,
    KIND_SEP     = 4'd6,
    KIND_DAQ     = 4'd7,
    KIND_IGNORED = 4'd8
  } kind_e;

  // Accepted input item
  typedef struct packed {
    logic                     mode;
    logic [WORD_W-1:0]        word;
    logic                     packet_start;
    logic [CH_W-1:0]          cal_channel;
    logic [ADC_W-1:0]         cal_threshold;
    logic signed [GAIN_W-1:0] cal_gain;
    logic signed [OFS_W-1:0]  cal_offset;
  } in_item_t;

  // Decoded item with the raw product, before scaling and offset
  typedef struct packed {
    kind_e                    kind;
    logic [CH_W-1:0]          channel;
    logic [ADC_W-1:0]         adc_value;
    logic signed [PROD_W-1:0] product;
    logic signed [OFS_W-1:0]  offset;
    logic                     counted;
    logic [EVT_W-1:0]         event_number;
    logic [WORD_W-1:0]        daq_counter;
    logic [STORE_W-1:0]       stored_channels;
  } dec_item_t;

  // Finished result item
  typedef struct packed {
    kind_e                      kind;
    logic [CH_W-1:0]            channel;
    logic [ADC_W-1:0]           adc_value;
    logic signed [ENERGY_W-1:0] energy;
    logic                       counted;
    logic [EVT_W-1:0]           event_number;
    logic [WORD_W-1:0]          daq_counter;
    logic [STORE_W-1:0]         stored_channels;
  } res_item_t;

endpackage

>>> src/qdc_block_word_decoder_core.sv
// QDC block word decoder: input register, decode and multiply stage, scale and output register.
//
//   channel  direction  handshake                fields
//   in       to block   in_valid_i / in_stall_o  mode, word, packet_start, cal_*
//   out      from block out_valid_o / out_stall_i kind, channel, adc_value, energy,
//                                                counted, event_number, daq_counter,
//                                                stored_channels
//
// One item per cycle sustained while the output is not stalled; a taken item passes
// through the decode/lookup/multiply register, then the scale/offset output register.
// Reset clears the packet flags, the word position, the pipeline valids and the
// calibration entry valid bits, so every table entry reads as zero until written.
// A stall on the output holds the output register; earlier stages keep filling any
// empty slot, and the input stalls only when all three registers are occupied.
module qdc_block_word_decoder_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               mode_i,
  input  logic [qdc_pkg::WORD_W-1:0]         word_i,
  input  logic                               packet_start_i,
  input  logic [qdc_pkg::CH_W-1:0]           cal_channel_i,
  input  logic [qdc_pkg::ADC_W-1:0]          cal_threshold_i,
  input  logic signed [qdc_pkg::GAIN_W-1:0]  cal_gain_i,
  input  logic signed [qdc_pkg::OFS_W-1:0]   cal_offset_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [qdc_pkg::KIND_W-1:0]         kind_o,
  output logic [qdc_pkg::CH_W-1:0]           channel_o,
  output logic [qdc_pkg::ADC_W-1:0]          adc_value_o,
  output logic signed [qdc_pkg::ENERGY_W-1:0] energy_o,
  output logic                               counted_o,
  output logic [qdc_pkg::EVT_W-1:0]          event_number_o,
  output logic [qdc_pkg::WORD_W-1:0]         daq_counter_o,
  output logic [qdc_pkg::STORE_W-1:0]        stored_channels_o
);
  import qdc_pkg::*;

  localparam logic signed [SUM_W-1:0] E_MAX = SUM_W'((64'sd1 <<< (ENERGY_W-1)) - 64'sd1);
  localparam logic signed [SUM_W-1:0] E_MIN = -SUM_W'(64'sd1 <<< (ENERGY_W-1));

  // Pipeline registers
  logic      a_valid_q, b_valid_q, c_valid_q;
  in_item_t  a_q;
  dec_item_t b_q, b_d;
  res_item_t c_q, c_d;

  // Packet state
  logic             sep_q, sep_d;
  logic             inv_q, inv_d;
  logic [POS_W-1:0] pos_q, pos_d;

  // Calibration tables, one valid bit per entry
  logic [ADC_W-1:0]         thr_q  [CHANNELS];
  logic signed [GAIN_W-1:0] gain_q [CHANNELS];
  logic signed [OFS_W-1:0]  ofs_q  [CHANNELS];
  logic [CHANNELS-1:0]      tbl_vld_q;

  logic c_ready, b_ready, a_ready;
  logic a_fire, b_fire, in_fire;
  logic cal_wr;

  // Stall chain: a stage moves when its successor is empty or moving
  assign c_ready    = !c_valid_q || !out_stall_i;
  assign b_ready    = !b_valid_q || c_ready;
  assign a_ready    = !a_valid_q || b_ready;
  assign in_stall_o = !a_ready;
  assign in_fire    = in_valid_i && a_ready;
  assign a_fire     = a_valid_q && b_ready;
  assign b_fire     = b_valid_q && c_ready;

  // Valids and packet state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
      sep_q     <= 1'b0;
      inv_q     <= 1'b0;
      pos_q     <= '0;
      tbl_vld_q <= '0;
    end else begin
      if (a_ready) a_valid_q <= in_valid_i;
      if (b_ready) b_valid_q <= a_valid_q;
      if (c_ready) c_valid_q <= b_valid_q;
      if (a_fire) begin
        sep_q <= sep_d;
        inv_q <= inv_d;
        pos_q <= pos_d;
      end
      if (cal_wr) tbl_vld_q[a_q.cal_channel[CH_IDX_W-1:0]] <= 1'b1;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      a_q.mode          <= mode_i;
      a_q.word          <= word_i;
      a_q.packet_start  <= packet_start_i;
      a_q.cal_channel   <= cal_channel_i;
      a_q.cal_threshold <= cal_threshold_i;
      a_q.cal_gain      <= cal_gain_i;
      a_q.cal_offset    <= cal_offset_i;
    end
    if (a_fire) b_q <= b_d;
    if (b_fire) c_q <= c_d;
    if (cal_wr) begin
      thr_q[a_q.cal_channel[CH_IDX_W-1:0]]  <= a_q.cal_threshold;
      gain_q[a_q.cal_channel[CH_IDX_W-1:0]] <= a_q.cal_gain;
      ofs_q[a_q.cal_channel[CH_IDX_W-1:0]]  <= a_q.cal_offset;
    end
  end

  assign cal_wr = a_fire && !a_q.mode &&
                  ({1'b0, a_q.cal_channel} < (CH_W + 1)'(CHANNELS));

  // Decode, table lookup and multiply
  always_comb begin
    logic                     sep_v, inv_v;
    logic [POS_W-1:0]         pos_v;
    logic [CH_W-1:0]          ch;
    logic [ADC_W-1:0]         value;
    logic                     hit;
    logic [ADC_W-1:0]         thr;
    logic signed [GAIN_W-1:0] gain;
    logic signed [OFS_W-1:0]  ofs;
    logic [2:0]               wtype;

    sep_v = a_q.packet_start ? 1'b0 : sep_q;
    inv_v = a_q.packet_start ? 1'b0 : inv_q;
    pos_v = a_q.packet_start ? '0 : pos_q;
    ch    = a_q.word[20:16];
    value = a_q.word[ADC_W-1:0];
    wtype = a_q.word[26:24];
    hit   = ({1'b0, ch} < (CH_W + 1)'(CHANNELS)) && tbl_vld_q[ch[CH_IDX_W-1:0]];
    thr   = hit ? thr_q[ch[CH_IDX_W-1:0]]  : '0;
    gain  = hit ? gain_q[ch[CH_IDX_W-1:0]] : '0;
    ofs   = hit ? ofs_q[ch[CH_IDX_W-1:0]]  : '0;

    b_d   = '0;
    sep_d = sep_q;
    inv_d = inv_q;
    pos_d = pos_q;

    if (!a_q.mode) begin
      b_d.kind = KIND_CAL;
    end else begin
      sep_d = sep_v;
      inv_d = inv_v;
      pos_d = pos_v;
      if ({1'b0, pos_v} < (POS_W + 1)'(HEADER_WORDS)) begin
        pos_d    = pos_v + 1'b1;
        b_d.kind = KIND_PKT_HDR;
      end else if (a_q.word[31:27] == SEP_CODE) begin
        sep_d    = 1'b1;
        b_d.kind = KIND_SEP;
      end else if (sep_v) begin
        b_d.kind        = KIND_DAQ;
        b_d.daq_counter = a_q.word;
      end else if (wtype == TYPE_HEADER) begin
        b_d.kind            = KIND_ADC_HDR;
        b_d.stored_channels = a_q.word[13:8];
      end else if (wtype == TYPE_DATUM && !inv_v) begin
        b_d.kind      = KIND_DATUM;
        b_d.channel   = ch;
        b_d.adc_value = value;
        b_d.product   = $signed({1'b0, value}) * gain;
        b_d.offset    = ofs;
        b_d.counted   = (value > thr) &&
                        ({1'b0, value} < CNT_LIM_W'(OVERFLOW_LEVEL - OVERFLOW_MARGIN));
      end else if (wtype == TYPE_EOE) begin
        b_d.kind         = KIND_EOE;
        b_d.event_number = a_q.word[EVT_W-1:0];
      end else if (wtype == TYPE_INVALID) begin
        inv_d    = 1'b1;
        b_d.kind = KIND_INVALID;
      end else begin
        b_d.kind = KIND_IGNORED;
      end
    end
  end

  // Drop the gain fraction (floor), add offset, saturate
  always_comb begin
    logic signed [SUM_W-1:0] sum;
    sum = SUM_W'(b_q.product >>> GAIN_FRACTION_BITS) + SUM_W'(b_q.offset);
    c_d.kind            = b_q.kind;
    c_d.channel         = b_q.channel;
    c_d.adc_value       = b_q.adc_value;
    c_d.counted         = b_q.counted;
    c_d.event_number    = b_q.event_number;
    c_d.daq_counter     = b_q.daq_counter;
    c_d.stored_channels = b_q.stored_channels;
    if (sum > E_MAX)      c_d.energy = E_MAX[ENERGY_W-1:0];
    else if (sum < E_MIN) c_d.energy = E_MIN[ENERGY_W-1:0];
    else                  c_d.energy = sum[ENERGY_W-1:0];
  end

  // Outputs
  assign out_valid_o       = c_valid_q;
  assign kind_o            = c_q.kind;
  assign channel_o         = c_q.channel;
  assign adc_value_o       = c_q.adc_value;
  assign energy_o          = c_q.energy;
  assign counted_o         = c_q.counted;
  assign event_number_o    = c_q.event_number;
  assign daq_counter_o     = c_q.daq_counter;
  assign stored_channels_o = c_q.stored_channels;

endmodule
